/* rtl/ft12_pkg.sv */
// shared types and constants of the ft12 frame receiver
package ft12_pkg;

  localparam logic [7:0] START_FIXED    = 8'h10;
  localparam logic [7:0] START_VAR      = 8'h68;
  localparam logic [8:0] LEN_FIXED      = 9'd5;
  localparam logic [8:0] LEN_VAR_EXTRA  = 9'd6;
  localparam logic [2:0] ADDR_POS_FIXED = 3'd2;
  localparam logic [2:0] ADDR_POS_VAR   = 3'd5;
  localparam int unsigned HOLD_DEPTH    = 5;
  localparam int unsigned RUN_DEPTH     = 6;

  // one run of result words released by a single input word
  typedef struct packed {
    logic [RUN_DEPTH-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      kind;
    logic [8:0]                base_pos;
    logic [8:0]                frame_len;
  } run_t;

endpackage

/* rtl/ft12_parser.sv */
// frame parser: start hunt, header hold, address match, run building
module ft12_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          station_address_i,
  output logic                load_o,
  output ft12_pkg::run_t      run_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HOLD = 2'd1,
    PH_FWD  = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       kind_q, kind_d;
  logic [8:0] pos_q, pos_d;
  logic [8:0] len_q, len_d;
  logic [ft12_pkg::HOLD_DEPTH-1:0][7:0] held_q, held_d;

  logic [2:0] addr_pos;
  logic [9:0] pos_inc;

  assign addr_pos = kind_q ? ft12_pkg::ADDR_POS_VAR : ft12_pkg::ADDR_POS_FIXED;
  assign pos_inc  = {1'b0, pos_q} + 10'd1;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    pos_d   = pos_q;
    len_d   = len_q;
    held_d  = held_q;
    load_o  = 1'b0;
    run_o   = '0;
    run_o.bytes     = '0;
    run_o.kind      = kind_q;
    run_o.base_pos  = pos_q;
    run_o.frame_len = len_q;
    unique case (phase_q)
      PH_HOLD: begin
        if (kind_q && pos_q == 9'd1) begin
          len_d = {1'b0, rx_byte_i} + ft12_pkg::LEN_VAR_EXTRA;
        end
        if (pos_q < {6'd0, addr_pos}) begin
          for (int i = 0; i < ft12_pkg::HOLD_DEPTH; i++) begin
            if (pos_q == 9'(i)) begin
              held_d[i] = rx_byte_i;
            end
          end
          pos_d = pos_inc[8:0];
        end else if (rx_byte_i != station_address_i) begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end else begin
          load_o         = 1'b1;
          run_o.count    = addr_pos + 3'd1;
          run_o.base_pos = '0;
          // held header then the address word
          for (int i = 0; i < ft12_pkg::RUN_DEPTH; i++) begin
            if (3'(i) < addr_pos && i < ft12_pkg::HOLD_DEPTH) begin
              run_o.bytes[i] = held_q[i];
            end else if (3'(i) == addr_pos) begin
              run_o.bytes[i] = rx_byte_i;
            end
          end
          if ({6'd0, addr_pos} + 9'd1 >= len_q) begin
            phase_d = PH_HUNT;
            pos_d   = '0;
          end else begin
            phase_d = PH_FWD;
            pos_d   = {6'd0, addr_pos} + 9'd1;
          end
        end
      end
      PH_FWD: begin
        load_o         = 1'b1;
        run_o.count    = 3'd1;
        run_o.bytes[0] = rx_byte_i;
        if (pos_inc >= {1'b0, len_q}) begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end else begin
          pos_d = pos_inc[8:0];
        end
      end
      default: begin
        // hunting, unused code acts the same
        if (rx_byte_i == ft12_pkg::START_FIXED || rx_byte_i == ft12_pkg::START_VAR) begin
          kind_d    = (rx_byte_i == ft12_pkg::START_VAR);
          len_d     = (rx_byte_i == ft12_pkg::START_VAR) ? ft12_pkg::LEN_VAR_EXTRA
                                                         : ft12_pkg::LEN_FIXED;
          held_d[0] = rx_byte_i;
          pos_d     = 9'd1;
          phase_d   = PH_HOLD;
        end else begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end
      end
    endcase
    if (!accept_i) begin
      load_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      kind_q  <= 1'b0;
      pos_q   <= '0;
      len_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

/* rtl/ft12_emitter.sv */
// result register: holds one run, hands out a word per cycle on ready_i
module ft12_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ft12_pkg::run_t run_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic           free_o,
  output logic [7:0]     out_byte_o,
  output logic           frame_kind_o,
  output logic           frame_start_o,
  output logic           frame_end_o,
  output logic           run_last_o
);

  logic                                   valid_q;
  logic [ft12_pkg::RUN_DEPTH-1:0][7:0]    buf_q;
  logic [2:0]                             cnt_q;
  logic                                   kind_q;
  logic [8:0]                             pos_q;
  logic [8:0]                             len_q;
  logic                                   take;

  assign take   = valid_q && ready_i;
  assign free_o = !valid_q || (ready_i && cnt_q == 3'd1);

  assign valid_o       = valid_q;
  assign out_byte_o    = buf_q[0];
  assign frame_kind_o  = kind_q;
  assign frame_start_o = (pos_q == 9'd0);
  assign frame_end_o   = ({1'b0, pos_q} + 10'd1) == {1'b0, len_q};
  assign run_last_o    = (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= run_i.count;
    end else if (take) begin
      valid_q <= (cnt_q != 3'd1);
      cnt_q   <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= run_i.bytes;
      kind_q <= run_i.kind;
      pos_q  <= run_i.base_pos;
      len_q  <= run_i.frame_len;
    end else if (take) begin
      // shift the next word to the head
      buf_q <= {8'h00, buf_q[ft12_pkg::RUN_DEPTH-1:1]};
      pos_q <= pos_q + 9'd1;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cnt_q != 3'd0 && cnt_q <= 3'd6))
    else $error("run count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || (ready_i && cnt_q == 3'd1)))
    else $error("run loaded over a pending word");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cnt_q != 3'd1 && !load_i) |=> (valid_q && pos_q == $past(pos_q) + 9'd1))
    else $error("run position did not advance");

endmodule

/* rtl/ft12_frame_receiver_unit.sv */
// top level of the ft12 frame receiver
//
// Line bytes enter on rx_valid_i / rx_ready_o / rx_byte_i. Words of frames
// addressed to this station leave on out_valid_o / out_ready_i with the byte,
// frame kind, start and end marks, and run_last on the final word caused by
// one input word. The user must write the station address through cfg_we_i
// and cfg_wdata_i only while the block is idle; it is not enforced here.
// A word that releases results shows its first result the cycle after it is
// accepted. The address word of a frame releases the held header as a run of
// 3 (fixed) or 6 (variable) results, one per cycle while out_ready_i is high;
// other frame words give one result; header words and idle bytes give none.
// Throughput is one word per cycle, limited by the single result register:
// a new word is taken when that register is empty or its last word leaves.
// When the receiver stalls, the pending word holds and rx_ready_o drops.
// Reset returns the parser to start hunting, empties the result register
// and clears the station address to 0.
module ft12_frame_receiver_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_kind_o,
  output logic       frame_start_o,
  output logic       frame_end_o,
  output logic       run_last_o
);

  logic           [7:0] station_address_q;
  logic                 accept;
  logic                 load;
  logic                 free;
  ft12_pkg::run_t       run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_address_q <= '0;
    end else if (cfg_we_i) begin
      station_address_q <= cfg_wdata_i;
    end
  end

  assign rx_ready_o = free;
  assign accept     = rx_valid_i && free;

  ft12_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .rx_byte_i         (rx_byte_i),
    .station_address_i (station_address_q),
    .load_o            (load),
    .run_o             (run)
  );

  ft12_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .run_i         (run),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .free_o        (free),
    .out_byte_o    (out_byte_o),
    .frame_kind_o  (frame_kind_o),
    .frame_start_o (frame_start_o),
    .frame_end_o   (frame_end_o),
    .run_last_o    (run_last_o)
  );

endmodule
